>>> rtl/idnr_pkg.sv
// ----------------------------------------------------------------------------
// idnr_pkg
// Shared types and constants of the int8 dense neuron with requantization.
// ----------------------------------------------------------------------------
package idnr_pkg;

  // field widths fixed by the interface
  localparam int DATA_W     = 8;
  localparam int BIAS_W     = 16;
  localparam int TERM_W     = 17;
  localparam int MULT_W     = 31;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // high multiply is split at this bit of the accumulator magnitude
  localparam int LO_SPLIT = 24;
  // division by 2^31 leaves this many bits to drop after the split
  localparam int Q_SHIFT  = 31 - LO_SPLIT;

  // rounding offsets of the doubling high multiply
  localparam logic [31:0] RND_POS = 32'h4000_0000;
  localparam logic [31:0] RND_NEG = 32'h3FFF_FFFF;

  // output saturation bounds
  localparam int SAT_MIN = -128;
  localparam int SAT_MAX = 127;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_ZP  = 2'd0,
    REG_OUT_ZP = 2'd1,
    REG_MULT   = 2'd2,
    REG_SHIFT  = 2'd3
  } cfg_reg_t;

  // one classified item on its way to the accumulator
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic signed [BIAS_W-1:0] bias;
    logic                     first;
    logic                     last;
  } idnr_item_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_ACC,
    BK_MAG,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_SHIFT,
    BK_SAT
  } back_state_t;

endpackage

>>> rtl/idnr_front.sv
// ----------------------------------------------------------------------------
// idnr_front
// Accepts input items, forms the zero-point corrected product term and
// hands the item to the queue.
// ----------------------------------------------------------------------------
module idnr_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [idnr_pkg::DATA_W-1:0]  activation,
  input  logic signed [idnr_pkg::DATA_W-1:0]  weight,
  input  logic signed [idnr_pkg::BIAS_W-1:0]  bias,
  input  logic                                first_term,
  input  logic                                last_term,
  input  logic signed [idnr_pkg::DATA_W-1:0]  input_zero_point,
  input  logic                                queue_full,
  output logic                                push,
  output idnr_pkg::idnr_item_t                push_item
);
  import idnr_pkg::*;

  logic                        stage_valid;
  idnr_item_t                  stage;
  logic signed [DATA_W:0]      diff;
  logic signed [TERM_W-1:0]    term;

  // product term, 9 by 8 bit signed
  assign diff = (DATA_W+1)'(activation) - (DATA_W+1)'(input_zero_point);
  assign term = TERM_W'(diff) * TERM_W'(weight);

  // one stage register, drained into the queue when it has room
  assign push      = stage_valid && !queue_full;
  assign in_ready  = !stage_valid || !queue_full;
  assign push_item = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.term  <= term;
      stage.bias  <= bias;
      stage.first <= first_term;
      stage.last  <= last_term;
    end
  end

endmodule

>>> rtl/idnr_queue.sv
// ----------------------------------------------------------------------------
// idnr_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module idnr_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  idnr_pkg::idnr_item_t  push_item,
  output logic                  full,
  input  logic                  pop,
  output idnr_pkg::idnr_item_t  pop_item,
  output logic                  not_empty
);
  import idnr_pkg::*;

  idnr_item_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a write");
`endif

endmodule

>>> rtl/idnr_back.sv
// ----------------------------------------------------------------------------
// idnr_back
// Accumulates queued terms and, at the end of a neuron, runs the
// requantization sequence: high multiply in two halves, rounding shift,
// output zero point and saturation.
// ----------------------------------------------------------------------------
module idnr_back #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  idnr_pkg::idnr_item_t                q_item,
  output logic                                pop,
  input  logic signed [idnr_pkg::DATA_W-1:0]  output_zero_point,
  input  logic [idnr_pkg::MULT_W-1:0]         multiplier,
  input  logic [idnr_pkg::SHIFT_W-1:0]        right_shift,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [idnr_pkg::DATA_W-1:0]  result
);
  import idnr_pkg::*;

  localparam int HI_W  = (ACC_WIDTH > LO_SPLIT) ? ACC_WIDTH - LO_SPLIT : 1;
  localparam int MAG_W = LO_SPLIT + HI_W;
  localparam int LO_W  = LO_SPLIT + MULT_W + 1;
  localparam int HS_W  = ((HI_W + MULT_W > 32) ? HI_W + MULT_W : 32) + 1;
  localparam int Q_W   = HS_W - Q_SHIFT;
  localparam int RM_W  = Q_W + 1;
  localparam int X_W   = (RM_W > 32) ? RM_W : 32;

  back_state_t                state;
  back_state_t                state_next;
  logic                       load_out;

  logic [ACC_WIDTH-1:0]       accumulator;
  logic [ACC_WIDTH-1:0]       accumulator_next;
  logic [MAG_W-1:0]           mag;
  logic                       mag_neg;
  logic [LO_W-1:0]            lo;
  logic signed [RM_W-1:0]     rm;
  logic signed [X_W-1:0]      shifted;

  logic [ACC_WIDTH-1:0]       abs_acc;
  logic [LO_W-1:0]            lo_calc;
  logic [HS_W-1:0]            hi_sum;
  logic [Q_W-1:0]             q;
  logic signed [X_W-1:0]      x_ext;
  logic signed [X_W-1:0]      x_floor;
  logic [31:0]                rem_mask;
  logic [31:0]                rem;
  logic [31:0]                thr;
  logic                       round_up;
  logic signed [X_W:0]        biased;
  logic signed [DATA_W-1:0]   sat_value;

  // accumulate, first term loads the bias
  always_comb begin
    accumulator_next = q_item.first
      ? {{(ACC_WIDTH-BIAS_W){q_item.bias[BIAS_W-1]}}, q_item.bias}
      : accumulator;
    accumulator_next = accumulator_next
      + {{(ACC_WIDTH-TERM_W){q_item.term[TERM_W-1]}}, q_item.term};
  end

  // magnitude of the accumulator
  assign abs_acc = accumulator[ACC_WIDTH-1] ? (~accumulator + 1'b1) : accumulator;

  // low half product plus rounding offset
  assign lo_calc = LO_W'(mag[LO_SPLIT-1:0]) * LO_W'(multiplier)
                 + LO_W'(mag_neg ? RND_NEG : RND_POS);

  // high half product plus carry in from the low half, then divide by 2^31
  assign hi_sum = HS_W'(mag[MAG_W-1:LO_SPLIT]) * HS_W'(multiplier)
                + HS_W'(lo[LO_W-1:LO_SPLIT]);
  assign q      = hi_sum[HS_W-1:Q_SHIFT];

  // rounding arithmetic right shift, ties away from zero
  assign x_ext    = X_W'(rm);
  assign x_floor  = x_ext >>> right_shift;
  assign rem_mask = (32'd1 << right_shift) - 32'd1;
  assign rem      = x_ext[31:0] & rem_mask;
  assign thr      = {1'b0, rem_mask[31:1]} + {31'd0, x_ext[X_W-1]};
  assign round_up = rem > thr;

  // output zero point and saturation
  assign biased = (X_W+1)'(shifted) + (X_W+1)'(output_zero_point);
  always_comb begin
    priority if (biased < (X_W+1)'(SAT_MIN)) begin
      sat_value = DATA_W'(SAT_MIN);
    end else if (biased > (X_W+1)'(SAT_MAX)) begin
      sat_value = DATA_W'(SAT_MAX);
    end else begin
      sat_value = biased[DATA_W-1:0];
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_ACC: begin
        pop = q_valid;
        if (q_valid && q_item.last) begin
          state_next = BK_MAG;
        end
      end
      BK_MAG:    state_next = BK_MUL_LO;
      BK_MUL_LO: state_next = BK_MUL_HI;
      BK_MUL_HI: state_next = BK_SHIFT;
      BK_SHIFT:  state_next = BK_SAT;
      BK_SAT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = BK_ACC;
        end
      end
      default:   state_next = BK_ACC;
    endcase
  end

  // accumulator and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        accumulator <= accumulator_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // requantization datapath
  always_ff @(posedge clk) begin
    if (state == BK_MAG) begin
      mag     <= MAG_W'(abs_acc);
      mag_neg <= accumulator[ACC_WIDTH-1];
    end
    if (state == BK_MUL_LO) begin
      lo <= lo_calc;
    end
    if (state == BK_MUL_HI) begin
      rm <= mag_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
    if (state == BK_SHIFT) begin
      shifted <= x_floor + $signed({{(X_W-1){1'b0}}, round_up});
    end
    if (load_out) begin
      result <= sat_value;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_starts_requant: assert property (@(posedge clk) disable iff (rst)
    (pop && q_item.last) |=> state == BK_MAG)
    else $error("last item did not start requantization");
  a_pop_only_accumulating: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == BK_ACC && q_valid))
    else $error("item taken outside accumulation");
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(result))
    else $error("pending result lost");
`endif

endmodule

>>> rtl/int8_dense_neuron_requantize.sv
// ----------------------------------------------------------------------------
// int8_dense_neuron_requantize
// One neuron of an int8 fully connected layer with Q31 requantization.
// ----------------------------------------------------------------------------
// a last item passes the front stage, the queue and states BK_MAG to BK_SAT
// throughput: 1 item per cycle while accumulating, set by the single mac
// a last item holds the back end in BK_MAG to BK_SAT for the requantize sequence
// the 4-entry queue lets the front keep taking items during that sequence
// reset: synchronous; clears accumulator, queue, handshakes, config to defaults
module int8_dense_neuron_requantize #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [idnr_pkg::DATA_W-1:0]      activation,
  input  logic signed [idnr_pkg::DATA_W-1:0]      weight,
  input  logic signed [idnr_pkg::BIAS_W-1:0]      bias,
  input  logic                                    first_term,
  input  logic                                    last_term,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [idnr_pkg::DATA_W-1:0]      result,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [idnr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [idnr_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import idnr_pkg::*;

  logic signed [DATA_W-1:0] input_zero_point;
  logic signed [DATA_W-1:0] output_zero_point;
  logic [MULT_W-1:0]        multiplier;
  logic [SHIFT_W-1:0]       right_shift;

  logic        push;
  idnr_item_t  push_item;
  logic        queue_full;
  logic        pop;
  idnr_item_t  pop_item;
  logic        queue_valid;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_zero_point  <= '0;
      output_zero_point <= '0;
      multiplier        <= MULT_W'(32'h4000_0000);
      right_shift       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IN_ZP:  input_zero_point  <= cfg_data[DATA_W-1:0];
        REG_OUT_ZP: output_zero_point <= cfg_data[DATA_W-1:0];
        REG_MULT:   multiplier        <= cfg_data[MULT_W-1:0];
        REG_SHIFT:  right_shift       <= cfg_data[SHIFT_W-1:0];
        default:    right_shift       <= right_shift;
      endcase
    end
  end

  // accept and form product terms
  idnr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .activation       (activation),
    .weight           (weight),
    .bias             (bias),
    .first_term       (first_term),
    .last_term        (last_term),
    .input_zero_point (input_zero_point),
    .queue_full       (queue_full),
    .push             (push),
    .push_item        (push_item)
  );

  // decoupling queue
  idnr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (queue_valid)
  );

  // accumulate and requantize
  idnr_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (queue_valid),
    .q_item            (pop_item),
    .pop               (pop),
    .output_zero_point (output_zero_point),
    .multiplier        (multiplier),
    .right_shift       (right_shift),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .result            (result)
  );

endmodule

>>> dv/tb_int8_dense_neuron_requantize.sv
// ----------------------------------------------------------------------------
// tb_int8_dense_neuron_requantize
// Self-checking bench for the int8 dense neuron with Q31 requantization.
// A directed table covers the field extremes, multi-item neurons, items
// carrying both marks, continuation after an emit and the register extremes.
// One long neuron with emits along the way builds a large running sum, and
// random neurons under four idle mixes and random register settings follow.
// Every neuron output is compared against a bit-accurate predictor kept in
// the bench, or against the result typed into the table for typed rows.
// ----------------------------------------------------------------------------
module tb_int8_dense_neuron_requantize;
  import idnr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SETTLE_CYCLES = 16;
  localparam int          DRAIN_LIMIT   = 20000;
  localparam int          TIMEOUT_NS    = 5_000_000;
  localparam int          LONG_ITEMS    = 48;
  localparam int          LONG_EMIT     = 16;
  localparam int          PHASE_ITEMS   = 110;
  localparam logic [30:0] MULT_MAX      = 31'h7FFF_FFFF;
  localparam logic [30:0] MULT_HALF     = 31'h4000_0000;

  // one row of the directed table: a register write or an item
  typedef struct packed {
    logic                     is_cfg;
    cfg_reg_t                 reg_idx;
    logic [30:0]              reg_data;
    logic signed [7:0]        act;
    logic signed [7:0]        wgt;
    logic signed [15:0]       bias_val;
    logic                     first;
    logic                     last;
    logic                     typed;
    logic signed [7:0]        typed_res;
  } step_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [DATA_W-1:0]   activation = '0;
  logic signed [DATA_W-1:0]   weight = '0;
  logic signed [BIAS_W-1:0]   bias = '0;
  logic                       first_term = 1'b0;
  logic                       last_term = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [DATA_W-1:0]   result;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // predictor state: register copies and the running sum
  logic signed [7:0]          zp_in = '0;
  logic signed [7:0]          zp_out = '0;
  logic [30:0]                q31_mult = MULT_HALF;
  logic [4:0]                 rshift = '0;
  logic signed [31:0]         neuron_sum = '0;

  logic signed [7:0]          pending_outputs[$];
  step_t                      steps[$];

  int unsigned                send_idle_pct = 0;
  int unsigned                recv_stall_pct = 0;
  int                         err_count = 0;
  int                         items_sent = 0;
  int                         outputs_checked = 0;
  int                         reg_writes = 0;

  int8_dense_neuron_requantize DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .activation (activation),
    .weight     (weight),
    .bias       (bias),
    .first_term (first_term),
    .last_term  (last_term),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // compare each neuron output against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", result));
      end else begin
        if (result !== pending_outputs[0]) begin
          report_mismatch($sformatf("result %0d, predicted %0d",
                                    result, pending_outputs[0]));
        end
        void'(pending_outputs.pop_front());
        outputs_checked++;
      end
    end
  end

  // rounding doubling high multiply, rounding shift, offset and clamp
  function automatic logic signed [7:0] requantize(input logic signed [31:0] acc);
    longint            sacc;
    longint unsigned   mag;
    longint unsigned   prod;
    longint            hm;
    longint            fl;
    longint            r;
    longint unsigned   mask;
    longint unsigned   rem;
    longint unsigned   thr;
    sacc = acc;
    mag  = (sacc < 0) ? longint'(-sacc) : longint'(sacc);
    prod = mag * longint'(q31_mult);
    prod = prod + ((sacc < 0) ? ((64'd1 << 30) - 64'd1) : (64'd1 << 30));
    hm   = longint'(prod >> 31);
    if (sacc < 0) hm = -hm;
    // ties of the shift go away from zero
    mask = (64'd1 << rshift) - 64'd1;
    rem  = longint'(hm) & mask;
    thr  = (mask >> 1) + ((hm < 0) ? 64'd1 : 64'd0);
    fl   = hm >>> rshift;
    r    = fl + ((rem > thr) ? 1 : 0);
    r    = r + longint'(zp_out);
    if (r < -128) r = -128;
    if (r > 127) r = 127;
    return 8'(r);
  endfunction

  // fold one item into the running sum, return the output it would emit
  function automatic logic signed [7:0] accumulate(input logic signed [7:0] a,
                                                   input logic signed [7:0] w,
                                                   input logic signed [15:0] b,
                                                   input logic f);
    longint prod_term;
    prod_term = (longint'(a) - longint'(zp_in)) * longint'(w);
    if (f) neuron_sum = b;
    neuron_sum = neuron_sum + 32'(prod_term);
    return requantize(neuron_sum);
  endfunction

  task automatic send_item(input logic signed [7:0] a, input logic signed [7:0] w,
                           input logic signed [15:0] b, input logic f, input logic l,
                           input logic typed, input logic signed [7:0] typed_res);
    logic signed [7:0] predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    activation <= a;
    weight     <= w;
    bias       <= b;
    first_term <= f;
    last_term  <= l;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = accumulate(a, w, b, f);
    if (l) pending_outputs.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [30:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_IN_ZP:  zp_in    = data[7:0];
      REG_OUT_ZP: zp_out   = data[7:0];
      REG_MULT:   q31_mult = data;
      REG_SHIFT:  rshift   = data[4:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending, wait out every pending output and the pipeline tail
  task automatic drain_to_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return -8'sd128;
      1:       return 8'sd127;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_bias();
    case ($urandom_range(7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic step_t cfg_row(input cfg_reg_t idx, input logic [30:0] data);
    step_t s;
    s          = '0;
    s.is_cfg   = 1'b1;
    s.reg_idx  = idx;
    s.reg_data = data;
    return s;
  endfunction

  function automatic step_t item_row(input logic signed [7:0] a,
                                     input logic signed [7:0] w,
                                     input logic signed [15:0] b,
                                     input logic f, input logic l,
                                     input logic typed,
                                     input logic signed [7:0] res);
    step_t s;
    s           = '0;
    s.act       = a;
    s.wgt       = w;
    s.bias_val  = b;
    s.first     = f;
    s.last      = l;
    s.typed     = typed;
    s.typed_res = res;
    return s;
  endfunction

  // register setting for a random phase, mostly in a useful output range
  task automatic load_random_setting();
    logic [30:0] m;
    logic [4:0]  s;
    m = ($urandom_range(3) != 0) ? 31'($urandom_range(32'h7FFF_FFFF, 32'h2000_0000))
                                 : 31'($urandom());
    s = ($urandom_range(3) != 0) ? 5'($urandom_range(12, 4)) : 5'($urandom_range(31));
    write_reg(REG_IN_ZP,  31'($urandom_range(255)));
    write_reg(REG_OUT_ZP, 31'($urandom_range(255)));
    write_reg(REG_MULT,   m);
    write_reg(REG_SHIFT,  31'(s));
  endtask

  // mostly well-formed neurons, some items with random marks
  task automatic run_random_phase(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(pick_byte(), pick_byte(), pick_bias(),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end else begin
        len = $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
          send_item(pick_byte(), pick_byte(), pick_bias(),
                    k == 0, k == len - 1, 1'b0, '0);
        end
        sent += len;
      end
    end
  endtask

  // main sequence
  initial begin
    // directed table, starting from the reset register values
    steps.push_back(item_row(8'sd0, 8'sd0, 16'sd0, 1, 1, 1, 8'sd0));
    steps.push_back(item_row(8'sd127, 8'sd127, 16'sd32767, 1, 1, 1, 8'sd127));
    steps.push_back(item_row(-8'sd128, 8'sd127, -16'sd32768, 1, 1, 1, -8'sd128));
    steps.push_back(item_row(-8'sd128, -8'sd128, 16'sd0, 1, 1, 1, 8'sd127));
    // neuron over several items, then continuation after the emit
    steps.push_back(item_row(8'sd3, 8'sd5, -16'sd7, 1, 0, 0, '0));
    steps.push_back(item_row(-8'sd4, 8'sd9, 16'sd1234, 0, 0, 0, '0));
    steps.push_back(item_row(8'sd100, -8'sd2, 16'sd0, 0, 1, 0, '0));
    steps.push_back(item_row(8'sd1, 8'sd1, -16'sd1, 0, 1, 0, '0));
    // the small value here, shifted down 31 places, lands on zero, leaving the offset
    steps.push_back(cfg_row(REG_IN_ZP,  31'(8'h80)));
    steps.push_back(cfg_row(REG_OUT_ZP, 31'(8'h7F)));
    steps.push_back(cfg_row(REG_MULT,   MULT_MAX));
    steps.push_back(cfg_row(REG_SHIFT,  31'd31));
    steps.push_back(item_row(8'sd127, -8'sd128, -16'sd32768, 1, 1, 1, 8'sd127));
    // zero multiplier leaves only the output offset
    steps.push_back(cfg_row(REG_IN_ZP,  31'(8'h7F)));
    steps.push_back(cfg_row(REG_OUT_ZP, 31'(8'h80)));
    steps.push_back(cfg_row(REG_MULT,   31'd0));
    steps.push_back(cfg_row(REG_SHIFT,  31'd0));
    steps.push_back(item_row(-8'sd128, -8'sd128, 16'sd32767, 1, 1, 1, -8'sd128));
    // rounding of the high multiply on both signs
    steps.push_back(cfg_row(REG_IN_ZP,  31'd0));
    steps.push_back(cfg_row(REG_OUT_ZP, 31'd0));
    steps.push_back(cfg_row(REG_MULT,   MULT_MAX));
    steps.push_back(item_row(8'sd1, 8'sd1, 16'sd0, 1, 1, 0, '0));
    steps.push_back(item_row(-8'sd1, 8'sd1, 16'sd0, 1, 1, 0, '0));
    // shift ties round away from zero, then ties of the high multiply
    steps.push_back(cfg_row(REG_MULT,   MULT_HALF));
    steps.push_back(cfg_row(REG_SHIFT,  31'd1));
    steps.push_back(item_row(8'sd6, 8'sd1, 16'sd0, 1, 1, 0, '0));
    steps.push_back(item_row(-8'sd6, 8'sd1, 16'sd0, 1, 1, 0, '0));
    steps.push_back(item_row(8'sd3, 8'sd1, 16'sd0, 1, 1, 0, '0));
    steps.push_back(item_row(-8'sd3, -8'sd1, 16'sd0, 1, 1, 0, '0));

    // reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        if (i == 0 || !steps[i-1].is_cfg) drain_to_idle();
        write_reg(steps[i].reg_idx, steps[i].reg_data);
      end else begin
        send_item(steps[i].act, steps[i].wgt, steps[i].bias_val, steps[i].first,
                  steps[i].last, steps[i].typed, steps[i].typed_res);
      end
    end

    // one long neuron with emits along the way, the sum kept across them
    drain_to_idle();
    write_reg(REG_IN_ZP,  31'(8'h80));
    write_reg(REG_OUT_ZP, 31'd0);
    write_reg(REG_MULT,   MULT_MAX);
    write_reg(REG_SHIFT,  31'd14);
    send_item(8'sd127, 8'sd127, 16'sd32767, 1, 0, 0, '0);
    for (int n = 1; n <= LONG_ITEMS; n++) begin
      send_item(8'sd127, 8'sd127, pick_bias(), 0,
                (n % LONG_EMIT) == 0 || n == LONG_ITEMS, 0, '0);
    end

    // random neurons under each idle mix
    for (int mode = 0; mode < 4; mode++) begin
      drain_to_idle();
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      load_random_setting();
      run_random_phase(PHASE_ITEMS);
    end

    drain_to_idle();
    while (pending_outputs.size() != 0) begin
      report_mismatch($sformatf("predicted output %0d never arrived", pending_outputs[0]));
      void'(pending_outputs.pop_front());
    end

    $display("covered %0d items and %0d neuron outputs over %0d register writes",
             items_sent, outputs_checked, reg_writes);
    $display("including a long neuron with partial emits and four sender/receiver idle mixes");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> int8_dense_neuron_requantize.f
rtl/idnr_pkg.sv
rtl/idnr_front.sv
rtl/idnr_queue.sv
rtl/idnr_back.sv
rtl/int8_dense_neuron_requantize.sv
dv/tb_int8_dense_neuron_requantize.sv
